### design/rgbhsv_pkg.sv
// shared types and constants for the rgb to hsv converter
// no dependencies; used by rgbhsv_div and rgb_to_hsv_converter
`default_nettype none

package rgbhsv_pkg;

   localparam int CHAN_W            = 8;
   localparam int HUE_W             = 15;
   localparam int SAT_W             = 16;
   localparam int DEF_HUE_FRAC_BITS = 6;
   localparam int DEF_SAT_BITS      = 16;
   localparam int DIV_DW            = CHAN_W + 1;
   localparam int DIV_STEPS         = 2;

   localparam logic [1:0] MAX_RED   = 2'd0;
   localparam logic [1:0] MAX_GREEN = 2'd1;
   localparam logic [1:0] MAX_BLUE  = 2'd2;

   typedef struct packed {
      logic [CHAN_W-1:0] value;
      logic [CHAN_W-1:0] alpha;
      logic              grey;
   } side_type;

endpackage

`default_nettype wire

### design/rgbhsv_div.sv
// pipelined restoring divider, up to STEPS quotient bits per register stage
// depends on rgbhsv_pkg for the default data width and step count
`default_nettype none

module rgbhsv_div #(
   parameter int QW    = 16,
   parameter int DW    = rgbhsv_pkg::DIV_DW,
   parameter int STEPS = rgbhsv_pkg::DIV_STEPS
) (
   input  wire logic                                clock,
   input  wire logic [(QW+STEPS-1)/STEPS-1:0]       en,
   input  wire logic [DW+QW-1:0]                    num,
   input  wire logic [DW-1:0]                       den,
   output logic      [QW-1:0]                       quo
);

   localparam int NDS = (QW + STEPS - 1) / STEPS;
   localparam int AW  = DW + QW;

   logic [AW-1:0] acc_ff [NDS];
   logic [DW-1:0] den_ff [NDS];

   for (genvar k = 0; k < NDS; k++) begin : g_stage
      localparam int NSTEP = ((QW - k * STEPS) < STEPS) ? (QW - k * STEPS) : STEPS;

      logic [AW-1:0] acc_src;
      logic [AW-1:0] acc_in;
      logic [DW-1:0] den_src;

      if (k == 0) begin : g_first
         assign acc_src = num;
         assign den_src = den;
      end else begin : g_next
         assign acc_src = acc_ff[k-1];
         assign den_src = den_ff[k-1];
      end

      always_comb begin : step
         logic [AW-1:0] a;
         logic [DW:0]   top;
         logic [DW:0]   sub;
         logic          ge;
         a = acc_src;
         for (int i = 0; i < NSTEP; i++) begin
            top = a[AW-1:QW-1];
            sub = top - {1'b0, den_src};
            ge  = (top >= {1'b0, den_src});
            a   = {(ge ? sub[DW-1:0] : top[DW-1:0]), a[QW-2:0], ge};
         end
         acc_in = a;
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            acc_ff[k] <= acc_in;
            den_ff[k] <= den_src;
         end
      end
   end

   assign quo = acc_ff[NDS-1][QW-1:0];

endmodule

`default_nettype wire

### design/rgb_to_hsv_converter.sv
// rgba pixel to hsv converter, top level
// depends on rgbhsv_pkg and rgbhsv_div
//
// Takes one pixel per clock when not stalled; one hsv result per pixel, in order.
// Hue comes out in 1/2^HUE_FRAC_BITS degree units, saturation scaled so that
// 2^SAT_BITS-1 means 1.0, brightness is the largest channel and alpha passes
// through. The two quotients come from two pipelined dividers that resolve two
// bits per stage. Each stage holds its own valid bit, so bubbles close up while
// the result side stalls.
`default_nettype none

module rgb_to_hsv_converter #(
   parameter int HUE_FRAC_BITS = rgbhsv_pkg::DEF_HUE_FRAC_BITS,
   parameter int SAT_BITS      = rgbhsv_pkg::DEF_SAT_BITS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [rgbhsv_pkg::CHAN_W-1:0]     req_red,
   input  wire logic [rgbhsv_pkg::CHAN_W-1:0]     req_green,
   input  wire logic [rgbhsv_pkg::CHAN_W-1:0]     req_blue,
   input  wire logic [rgbhsv_pkg::CHAN_W-1:0]     req_alpha,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic      [rgbhsv_pkg::HUE_W-1:0]      rsp_hue,
   output logic      [rgbhsv_pkg::SAT_W-1:0]      rsp_saturation,
   output logic      [rgbhsv_pkg::CHAN_W-1:0]     rsp_brightness,
   output logic      [rgbhsv_pkg::CHAN_W-1:0]     rsp_alpha_out
);

   localparam int CW    = rgbhsv_pkg::CHAN_W;
   localparam int DW    = rgbhsv_pkg::DIV_DW;
   localparam int STEPS = rgbhsv_pkg::DIV_STEPS;
   localparam int HW    = rgbhsv_pkg::HUE_W;
   localparam int SW    = rgbhsv_pkg::SAT_W;
   localparam int HQ    = $clog2((360 << HUE_FRAC_BITS) + 1);
   localparam int QW    = (HQ > SAT_BITS) ? HQ : SAT_BITS;
   localparam int AW    = QW + DW;
   localparam int NDS   = (QW + STEPS - 1) / STEPS;
   localparam int NT    = NDS + 4;

   localparam logic [QW-1:0] FULL = QW'(360 << HUE_FRAC_BITS);
   localparam logic [AW-1:0] SMAX = AW'((64'd1 << SAT_BITS) - 64'd1);

   // stage control
   logic [NT-1:0] v_ff;
   logic [NT-1:0] v_in;
   logic [NT-1:0] rdy;
   logic [NT-1:0] vin;
   logic [NT-1:0] en;

   always_comb begin
      rdy[NT-1] = !v_ff[NT-1] || rsp_ready;
      for (int i = NT - 2; i >= 0; i--) begin
         rdy[i] = !v_ff[i] || rdy[i+1];
      end
   end

   assign vin  = {v_ff[NT-2:0], req_valid};
   assign en   = rdy & vin;
   assign v_in = (rdy & vin) | (~rdy & v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_ready = rdy[0];
   assign rsp_valid = v_ff[NT-1];

   // input register
   logic [CW-1:0] red_ff, green_ff, blue_ff, alpha0_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         red_ff    <= req_red;
         green_ff  <= req_green;
         blue_ff   <= req_blue;
         alpha0_ff <= req_alpha;
      end
   end

   // max, min, chroma and hue difference
   logic [CW-1:0]        value_in, value_ff, mn;
   logic [CW-1:0]        chroma_in, chroma_ff;
   logic [1:0]           sel_in, sel_ff;
   logic signed [CW:0]   diff_in, diff_ff;
   logic [CW-1:0]        alpha1_ff;

   always_comb begin
      value_in = red_ff;
      if (green_ff > value_in) value_in = green_ff;
      if (blue_ff > value_in) value_in = blue_ff;
      mn = red_ff;
      if (green_ff < mn) mn = green_ff;
      if (blue_ff < mn) mn = blue_ff;
      chroma_in = value_in - mn;
      if (red_ff == value_in) begin
         sel_in  = rgbhsv_pkg::MAX_RED;
         diff_in = $signed({1'b0, green_ff}) - $signed({1'b0, blue_ff});
      end else if (green_ff == value_in) begin
         sel_in  = rgbhsv_pkg::MAX_GREEN;
         diff_in = $signed({1'b0, blue_ff}) - $signed({1'b0, red_ff});
      end else begin
         sel_in  = rgbhsv_pkg::MAX_BLUE;
         diff_in = $signed({1'b0, red_ff}) - $signed({1'b0, green_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         value_ff  <= value_in;
         chroma_ff <= chroma_in;
         sel_ff    <= sel_in;
         diff_ff   <= diff_in;
         alpha1_ff <= alpha0_ff;
      end
   end

   // dividends and divisors
   logic signed [18:0]    dx, cx, base, num;
   logic [AW-1:0]         hue_num_in, hue_num_ff, sat_num_in, sat_num_ff;
   logic [DW-1:0]         hue_den_ff, sat_den_ff;
   rgbhsv_pkg::side_type  side2_in, side2_ff;

   always_comb begin
      dx = 19'(diff_ff);
      cx = $signed({11'b0, chroma_ff});
      case (sel_ff)
         rgbhsv_pkg::MAX_RED:   base = '0;
         rgbhsv_pkg::MAX_GREEN: base = cx * 19'sd120;
         rgbhsv_pkg::MAX_BLUE:  base = cx * 19'sd240;
         default:               base = '0;
      endcase
      num = dx * 19'sd60 + base;
      if (num < 0) num = num + cx * 19'sd360;
      hue_num_in = (AW'(num[16:0]) << (HUE_FRAC_BITS + 1)) + AW'(chroma_ff);
      sat_num_in = ((AW'(chroma_ff) * SMAX) << 1) + AW'(value_ff);
      side2_in.value = value_ff;
      side2_in.alpha = alpha1_ff;
      side2_in.grey  = (chroma_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         hue_num_ff <= hue_num_in;
         hue_den_ff <= {chroma_ff, 1'b0};
         sat_num_ff <= sat_num_in;
         sat_den_ff <= {value_ff, 1'b0};
         side2_ff   <= side2_in;
      end
   end

   // division stages
   logic [QW-1:0]         hue_quo, sat_quo;
   rgbhsv_pkg::side_type  side_ff [NDS];

   rgbhsv_div #(
      .QW    (QW),
      .DW    (DW),
      .STEPS (STEPS)
   ) u_hue_div (
      .clock (clock),
      .en    (en[NT-2:3]),
      .num   (hue_num_ff),
      .den   (hue_den_ff),
      .quo   (hue_quo)
   );

   rgbhsv_div #(
      .QW    (QW),
      .DW    (DW),
      .STEPS (STEPS)
   ) u_sat_div (
      .clock (clock),
      .en    (en[NT-2:3]),
      .num   (sat_num_ff),
      .den   (sat_den_ff),
      .quo   (sat_quo)
   );

   for (genvar k = 0; k < NDS; k++) begin : g_side
      always_ff @(posedge clock) begin
         if (en[3+k]) begin
            side_ff[k] <= (k == 0) ? side2_ff : side_ff[(k == 0) ? 0 : k - 1];
         end
      end
   end

   // hue wrap, special cases and output register
   logic [QW-1:0]      hue_fix, sat_fix;
   logic [QW+HW-1:0]   hue_ext;
   logic [QW+SW-1:0]   sat_ext;
   logic [HW-1:0]      rsp_hue_in, rsp_hue_ff;
   logic [SW-1:0]      rsp_sat_in, rsp_sat_ff;
   logic [CW-1:0]      rsp_bright_ff, rsp_alpha_ff;

   always_comb begin
      hue_fix = (hue_quo >= FULL) ? hue_quo - FULL : hue_quo;
      if (side_ff[NDS-1].grey) hue_fix = '0;
      sat_fix = (side_ff[NDS-1].value == '0) ? '0 : sat_quo;
      hue_ext = {{HW{1'b0}}, hue_fix};
      sat_ext = {{SW{1'b0}}, sat_fix};
      rsp_hue_in = hue_ext[HW-1:0];
      rsp_sat_in = sat_ext[SW-1:0];
   end

   always_ff @(posedge clock) begin
      if (en[NT-1]) begin
         rsp_hue_ff    <= rsp_hue_in;
         rsp_sat_ff    <= rsp_sat_in;
         rsp_bright_ff <= side_ff[NDS-1].value;
         rsp_alpha_ff  <= side_ff[NDS-1].alpha;
      end
   end

   assign rsp_hue        = rsp_hue_ff;
   assign rsp_saturation = rsp_sat_ff;
   assign rsp_brightness = rsp_bright_ff;
   assign rsp_alpha_out  = rsp_alpha_ff;

endmodule

`default_nettype wire
